### design/tsewc_pkg.sv
// ----------------------------------------------------------------------------
// tsewc_pkg
// Shared types and constants of the two-side energy weighted centroid block.
// ----------------------------------------------------------------------------
package tsewc_pkg;

  // field and accumulator widths
  localparam int unsigned CoordW     = 16;
  localparam int unsigned EnergyW    = 16;
  localparam int unsigned SumW       = 48;
  localparam int unsigned ESumW      = 32;
  localparam int unsigned EOutW      = 28;
  localparam int unsigned MulW       = 18;
  localparam int unsigned ProdW      = 2 * MulW;
  localparam int unsigned InDataW    = 4 * CoordW;
  localparam int unsigned OutDataW   = 4 * CoordW + 2 * EOutW;
  localparam int unsigned OutUserW   = 2;

  // divider: one quotient bit per step over the full sum width
  localparam int unsigned DivBits    = SumW;
  localparam int unsigned StepW      = $clog2(DivBits);

  // hit limit per event
  localparam int unsigned MaxHitsDef = 4096;

  // configuration port
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam logic        RegCrossingSlope = 1'b0;
  localparam logic [15:0] SlopeReset = 16'd459;   // 0.007 in Q0.16

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORR,
    S_MULX,
    S_MULY,
    S_ACCY,
    S_DLOAD,
    S_DSTEP,
    S_DDONE,
    S_OUT
  } state_e;

endpackage

### design/two_side_energy_weighted_centroid.sv
// ----------------------------------------------------------------------------
// two_side_energy_weighted_centroid
// Energy weighted x/y barycenters of calorimeter hits, split by sign of z.
// ----------------------------------------------------------------------------
// Usage:
//   Hits come in on the s_axis channel, one word per hit; tlast marks the
//   last hit of an event. Each hit's x is corrected by |z| * crossing_slope
//   (Q0.16), then energy, energy*x and energy*y are accumulated for the side
//   chosen by z (z >= 0 positive, z < 0 negative). Past MAX_HITS hits in an
//   event further hits only count for tlast.
//   On the last hit one result word goes out on m_axis: both barycenters
//   (truncated toward zero, clamped to 16 bits) and both side energies
//   (clamped to 28 bits); tuser flags a side with nonzero energy.
// Resources and sequencing:
//   One shared 18x18 multiplier and one 48-bit adder serve a hit in the
//   states CORR, MULX, MULY and ACCY after acceptance; no new hit is taken
//   until it is through, and a hit past the limit skips them. The four
//   divisions share one restoring divider, each as load, 48 quotient bits,
//   store; the result word is registered once all four are done and m_axis is free.
// Reset clears all sums, the hit count and the output valid bit; the slope
//   returns to 459. A stalled m_axis holds the result; the block keeps taking
//   hits of the next event and only waits when its next result is ready.
// ----------------------------------------------------------------------------
module two_side_energy_weighted_centroid #(
  parameter int unsigned MAX_HITS = tsewc_pkg::MaxHitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // hit stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // {pos_z, pos_y, pos_x, hit_energy}, hit_energy at bit 0
  input  logic [tsewc_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                              s_axis_tlast,   // last_hit
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pos_bary_x, pos_bary_y, neg_bary_x, neg_bary_y, pos_energy, neg_energy
  output logic [tsewc_pkg::OutDataW-1:0]    m_axis_tdata,
  // pos_valid, neg_valid
  output logic [tsewc_pkg::OutUserW-1:0]    m_axis_tuser,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tsewc_pkg::ApbAddrW-1:0]    paddr,
  input  logic [tsewc_pkg::ApbDataW-1:0]    pwdata,
  output logic [tsewc_pkg::ApbDataW-1:0]    prdata,
  output logic                              pready
);
  import tsewc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_HITS + 1);

  state_e state_q, state_d;

  // configuration
  logic [15:0] slope_q;
  logic        cfg_wr;

  // latched hit
  logic [EnergyW-1:0] e_q, e_d;
  logic [CoordW-1:0]  x_q, x_d, y_q, y_d, z_q, z_d;
  logic               last_q, last_d;

  // accumulators
  logic signed [SumW-1:0] psx_q, psx_d, psy_q, psy_d, nsx_q, nsx_d, nsy_q, nsy_d;
  logic [ESumW-1:0]       pse_q, pse_d, nse_q, nse_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  // shared multiplier
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p, prod_q, prod_d;

  // shared adder
  logic signed [SumW-1:0]  add_a, add_b, add_r;

  // corrected x
  logic [CoordW:0]          abs_z;
  logic signed [MulW-1:0]   xdiff, xc;

  // divider
  logic [1:0]              idx_q, idx_d;
  logic [StepW-1:0]        step_q, step_d;
  logic [ESumW-1:0]        den_q, den_d;
  logic [ESumW-1:0]        rem_q, rem_d;
  logic [DivBits-1:0]      dq_q, dq_d;
  logic                    neg_q, neg_d;
  logic signed [SumW-1:0]  div_sum;
  logic [ESumW:0]          trial;
  logic                    trial_ge;
  logic [CoordW-1:0]       bary_res;
  logic [3:0][CoordW-1:0]  bary_q, bary_d;

  // output register
  logic                    ovalid_q, ovalid_d;
  logic [OutDataW-1:0]     odata_q, odata_d;
  logic [OutUserW-1:0]     ouser_q, ouser_d;
  logic [EOutW-1:0]        pe_sat, ne_sat;

  logic in_fire, out_free, acc_ok;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign acc_ok   = cnt_q < CntW'(MAX_HITS);

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegCrossingSlope);
  assign prdata = (paddr[2] == RegCrossingSlope) ? {{(ApbDataW-16){1'b0}}, slope_q}
                                                 : '0;

  // ---------------- arithmetic ----------------
  assign mul_p = mul_a * mul_b;
  assign add_r = add_a + add_b;

  // |z| needs 17 bits for -32768
  assign abs_z = z_q[CoordW-1] ? ((CoordW+1)'(0) - {z_q[CoordW-1], z_q}) : {1'b0, z_q};

  // x minus the crossing correction, clamped at the bottom
  always_comb begin
    xdiff = MulW'($signed(x_q)) - $signed({2'b00, prod_q[31:16]});
    if (xdiff < -MulW'(32768)) begin
      xc = -MulW'(32768);
    end else begin
      xc = xdiff;
    end
  end

  // one restoring step
  assign trial    = {rem_q, dq_q[DivBits-1]};
  assign trial_ge = trial >= {1'b0, den_q};

  always_comb begin
    case (idx_q)
      2'd0:    div_sum = psx_q;
      2'd1:    div_sum = psy_q;
      2'd2:    div_sum = nsx_q;
      default: div_sum = nsy_q;
    endcase
  end

  // clamp the quotient magnitude into a signed 16-bit result; zero for a zero energy sum
  always_comb begin
    if (den_q == '0) begin
      bary_res = '0;
    end else if (neg_q) begin
      if ((|dq_q[DivBits-1:16]) || (dq_q[15] && (|dq_q[14:0]))) begin
        bary_res = 16'h8000;
      end else begin
        bary_res = 16'd0 - dq_q[15:0];
      end
    end else begin
      if (|dq_q[DivBits-1:15]) begin
        bary_res = 16'h7fff;
      end else begin
        bary_res = dq_q[15:0];
      end
    end
  end

  assign pe_sat = (|pse_q[ESumW-1:EOutW]) ? {EOutW{1'b1}} : pse_q[EOutW-1:0];
  assign ne_sat = (|nse_q[ESumW-1:EOutW]) ? {EOutW{1'b1}} : nse_q[EOutW-1:0];

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (acc_ok) begin
            state_d = S_CORR;
          end else if (s_axis_tlast) begin
            state_d = S_DLOAD;
          end
        end
      end
      S_CORR:  state_d = S_MULX;
      S_MULX:  state_d = S_MULY;
      S_MULY:  state_d = S_ACCY;
      S_ACCY:  state_d = last_q ? S_DLOAD : S_IDLE;
      S_DLOAD: state_d = S_DSTEP;
      S_DSTEP: begin
        if (step_q == StepW'(DivBits - 1)) begin
          state_d = S_DDONE;
        end
      end
      S_DDONE: state_d = (idx_q == 2'd3) ? S_OUT : S_DLOAD;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- datapath control ----------------
  always_comb begin
    e_d = e_q; x_d = x_q; y_d = y_q; z_d = z_q; last_d = last_q;
    psx_d = psx_q; psy_d = psy_q; nsx_d = nsx_q; nsy_d = nsy_q;
    pse_d = pse_q; nse_d = nse_q; cnt_d = cnt_q;
    prod_d = prod_q;
    idx_d = idx_q; step_d = step_q; den_d = den_q; rem_d = rem_q;
    dq_d = dq_q; neg_d = neg_q; bary_d = bary_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d = odata_q; ouser_d = ouser_q;
    mul_a = '0;
    mul_b = '0;
    add_a = '0;
    add_b = SumW'($signed(prod_q[32:0]));

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          e_d    = s_axis_tdata[15:0];
          x_d    = s_axis_tdata[31:16];
          y_d    = s_axis_tdata[47:32];
          z_d    = s_axis_tdata[63:48];
          last_d = s_axis_tlast;
          idx_d  = 2'd0;
        end
      end
      S_CORR: begin
        mul_a  = {1'b0, abs_z};
        mul_b  = {2'b00, slope_q};
        prod_d = mul_p;
      end
      S_MULX: begin
        mul_a  = {2'b00, e_q};
        mul_b  = xc;
        prod_d = mul_p;
      end
      S_MULY: begin
        add_a = z_q[CoordW-1] ? nsx_q : psx_q;
        if (z_q[CoordW-1]) begin
          nsx_d = add_r;
        end else begin
          psx_d = add_r;
        end
        mul_a  = {2'b00, e_q};
        mul_b  = MulW'($signed(y_q));
        prod_d = mul_p;
      end
      S_ACCY: begin
        add_a = z_q[CoordW-1] ? nsy_q : psy_q;
        if (z_q[CoordW-1]) begin
          nsy_d = add_r;
          nse_d = nse_q + ESumW'(e_q);
        end else begin
          psy_d = add_r;
          pse_d = pse_q + ESumW'(e_q);
        end
        cnt_d = cnt_q + CntW'(1);
      end
      S_DLOAD: begin
        den_d  = idx_q[1] ? nse_q : pse_q;
        neg_d  = div_sum[SumW-1];
        dq_d   = div_sum[SumW-1] ? DivBits'(-div_sum) : DivBits'(div_sum);
        rem_d  = '0;
        step_d = '0;
      end
      S_DSTEP: begin
        rem_d  = trial_ge ? ESumW'(trial - {1'b0, den_q}) : trial[ESumW-1:0];
        dq_d   = {dq_q[DivBits-2:0], trial_ge};
        step_d = step_q + StepW'(1);
      end
      S_DDONE: begin
        bary_d[idx_q] = bary_res;
        idx_d = idx_q + 2'd1;
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = {ne_sat, pe_sat, bary_q[3], bary_q[2], bary_q[1], bary_q[0]};
          ouser_d  = {nse_q != '0, pse_q != '0};
          psx_d = '0; psy_d = '0; nsx_d = '0; nsy_d = '0;
          pse_d = '0; nse_d = '0; cnt_d = '0;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      slope_q  <= SlopeReset;
      psx_q    <= '0;
      psy_q    <= '0;
      nsx_q    <= '0;
      nsy_q    <= '0;
      pse_q    <= '0;
      nse_q    <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_wr) begin
        slope_q <= pwdata[15:0];
      end
      psx_q    <= psx_d;
      psy_q    <= psy_d;
      nsx_q    <= nsx_d;
      nsy_q    <= nsy_d;
      pse_q    <= pse_d;
      nse_q    <= nse_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q     <= e_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    last_q  <= last_d;
    prod_q  <= prod_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    dq_q    <= dq_d;
    neg_q   <= neg_d;
    bary_q  <= bary_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule
